// ===== rtl/core/cbm_pkg.sv =====
`timescale 1ns / 1ps

package cbm_pkg;

	localparam int DIVIDEND_W = 9;
	localparam int DIVISOR_W  = 10;
	localparam int STEP_CNT_W = 4;

	localparam logic [1:0] KIND_WRITE = 2'd0;
	localparam logic [1:0] KIND_ROM   = 2'd1;
	localparam logic [1:0] KIND_RAM   = 2'd2;

	localparam logic [1:0] CFG_CART_TYPE = 2'd0;
	localparam logic [1:0] CFG_ROM_BANKS = 2'd1;
	localparam logic [1:0] CFG_RAM_BANKS = 2'd2;

	localparam logic [7:0] MBC3_FIRST = 8'h0F;
	localparam logic [7:0] MBC3_LAST  = 8'h13;
	localparam logic [7:0] MBC5_FIRST = 8'h19;
	localparam logic [7:0] MBC5_LAST  = 8'h1E;

	localparam logic [3:0] RAM_EN_KEY = 4'hA;
	localparam logic [2:0] RAM_WINDOW = 3'b101;

	typedef enum logic [1:0] {
		MAP_MBC1,
		MAP_MBC3,
		MAP_MBC5
	} map_t;

	typedef struct packed {
		map_t                   map;
		logic [DIVISOR_W-1:0]   rom_banks;
		logic [4:0]             ram_banks;
		logic                   ram_enable;
		logic [4:0]             low_bank;
		logic [1:0]             high_bank;
		logic                   bank_mode;
		logic [8:0]             wide_rom_bank;
		logic [7:0]             wide_ram_sel;
	} bank_state_t;

	function automatic map_t map_of(input logic [7:0] cart_type);
		map_t m;
		m = MAP_MBC1;
		if (cart_type >= MBC3_FIRST && cart_type <= MBC3_LAST) begin
			m = MAP_MBC3;
		end else if (cart_type >= MBC5_FIRST && cart_type <= MBC5_LAST) begin
			m = MAP_MBC5;
		end
		return m;
	endfunction

endpackage

// ===== rtl/core/cbm_regs.sv =====
`timescale 1ns / 1ps

module cbm_regs (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [1:0]           cfg_index,
	input  logic [9:0]           cfg_data,
	input  logic                 bus_we,
	input  logic [15:0]          bus_addr,
	input  logic [7:0]           bus_data,
	output cbm_pkg::bank_state_t st
);

	logic [7:0] cart_type_q;
	logic [9:0] rom_banks_q;
	logic [4:0] ram_banks_q;
	logic       ram_enable_q;
	logic [4:0] low_bank_q;
	logic [1:0] high_bank_q;
	logic       bank_mode_q;
	logic [8:0] wide_rom_bank_q;
	logic [7:0] wide_ram_sel_q;
	cbm_pkg::map_t map;
	logic [2:0] region;

	assign map    = cbm_pkg::map_of(cart_type_q);
	assign region = bus_addr[15:13];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cart_type_q <= 8'd0;
			rom_banks_q <= 10'd2;
			ram_banks_q <= 5'd0;
		end else if (cfg_we) begin
			case (cfg_index)
				cbm_pkg::CFG_CART_TYPE: cart_type_q <= cfg_data[7:0];
				cbm_pkg::CFG_ROM_BANKS: rom_banks_q <= cfg_data;
				cbm_pkg::CFG_RAM_BANKS: ram_banks_q <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ram_enable_q    <= 1'b0;
			low_bank_q      <= 5'd1;
			high_bank_q     <= 2'd0;
			bank_mode_q     <= 1'b0;
			wide_rom_bank_q <= 9'd1;
			wide_ram_sel_q  <= 8'd0;
		end else if (bus_we) begin
			if (region == 3'd0) begin
				ram_enable_q <= (bus_data[3:0] == cbm_pkg::RAM_EN_KEY);
			end else begin
				case (map)
					cbm_pkg::MAP_MBC3: begin
						if (region == 3'd1) begin
							wide_rom_bank_q <= (bus_data[6:0] == 7'd0) ? 9'd1
								: {2'b00, bus_data[6:0]};
						end else if (region == 3'd2) begin
							wide_ram_sel_q <= bus_data;
						end
					end
					cbm_pkg::MAP_MBC5: begin
						if (region == 3'd1 && !bus_addr[12]) begin
							wide_rom_bank_q[7:0] <= bus_data;
						end else if (region == 3'd1) begin
							wide_rom_bank_q[8] <= bus_data[0];
						end else if (region == 3'd2) begin
							wide_ram_sel_q <= {4'd0, bus_data[3:0]};
						end
					end
					default: begin
						if (region == 3'd1) begin
							low_bank_q <= (bus_data[4:0] == 5'd0) ? 5'd1 : bus_data[4:0];
						end else if (region == 3'd2) begin
							high_bank_q <= bus_data[1:0];
						end else if (region == 3'd3) begin
							bank_mode_q <= bus_data[0];
						end
					end
				endcase
			end
		end
	end

	always_comb begin
		st.map           = map;
		st.rom_banks     = rom_banks_q;
		st.ram_banks     = ram_banks_q;
		st.ram_enable    = ram_enable_q;
		st.low_bank      = low_bank_q;
		st.high_bank     = high_bank_q;
		st.bank_mode     = bank_mode_q;
		st.wide_rom_bank = wide_rom_bank_q;
		st.wide_ram_sel  = wide_ram_sel_q;
	end

endmodule

// ===== rtl/core/cbm_divrem.sv =====
`timescale 1ns / 1ps

module cbm_divrem (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic [cbm_pkg::DIVIDEND_W-1:0]   dividend,
	input  logic [cbm_pkg::DIVISOR_W-1:0]    divisor,
	output logic                             done,
	output logic [cbm_pkg::DIVIDEND_W-1:0]   rem
);

	localparam logic [cbm_pkg::STEP_CNT_W-1:0] LAST_STEP =
		cbm_pkg::STEP_CNT_W'(cbm_pkg::DIVIDEND_W - 1);

	logic                              busy_q;
	logic                              done_q;
	logic [cbm_pkg::STEP_CNT_W-1:0]    cnt_q;
	logic [cbm_pkg::DIVISOR_W-1:0]     div_q;
	logic [cbm_pkg::DIVISOR_W-1:0]     rem_q;
	logic [cbm_pkg::DIVIDEND_W-1:0]    shift_q;
	logic [cbm_pkg::DIVISOR_W:0]       trial;
	logic                              fits;

	assign trial = {rem_q, shift_q[cbm_pkg::DIVIDEND_W-1]};
	assign fits  = (trial >= {1'b0, div_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == LAST_STEP) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			div_q   <= divisor;
			rem_q   <= '0;
			shift_q <= dividend;
		end else if (busy_q) begin
			rem_q   <= fits ? cbm_pkg::DIVISOR_W'(trial - {1'b0, div_q})
				: trial[cbm_pkg::DIVISOR_W-1:0];
			shift_q <= {shift_q[cbm_pkg::DIVIDEND_W-2:0], 1'b0};
		end
	end

	assign done = done_q;
	assign rem  = rem_q[cbm_pkg::DIVIDEND_W-1:0];

	a_rem_below_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (rem_q < div_q))
		else $error("remainder not below divisor");

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> (busy_q && !done_q))
		else $error("divider did not start");

	a_last_step_done: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && !start && cnt_q == LAST_STEP) |=> (done_q && !busy_q))
		else $error("divider did not finish after last step");

endmodule

// ===== rtl/core/cartridge_bank_mapper.sv =====
`timescale 1ns / 1ps
// Cartridge bank controller (MBC1 / MBC3 / MBC5 rules by cartridge type byte).
// Channels:
//   cfg  : cfg_valid/cfg_ready with cfg_index and cfg_data; 0 cart_type,
//          1 rom_banks, 2 ram_banks. Always ready, one register per transaction.
//   in   : in_valid/in_ready with kind, address, data_byte. kind 0 is a bus
//          write to the bank registers, taken with no result.
//          kind 1 / 2 are ROM / RAM translations; kind 3 is dropped.
//   out  : out_valid/out_ready with offset and ram_ok, one per translation.
// Sequence: a translation starts a bit-serial remainder (bank mod bank count)
// on the cycle it is accepted; when the remainder is done, the result is loaded
// into the output register and out_valid rises. in_ready is low for the whole
// translation, so a new translation is taken only after the last result is
// loaded; bus writes are taken every cycle while no translation is in flight.
// Stall: a result waiting in the output register holds the sequencer until
// it is taken, but bus writes and a new translation may be accepted while an
// earlier result waits.
// Reset: cart_type 0, rom_banks 2, ram_banks 0; RAM disabled, ROM bank 1,
// all other bank registers 0; no result pending.

module cartridge_bank_mapper (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [9:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  kind,
	input  logic [15:0] address,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [22:0] offset,
	output logic        ram_ok
);

	typedef enum logic {
		ST_IDLE,
		ST_BUSY
	} state_t;

	state_t                                state_q;
	logic                                  is_rom_q;
	logic [15:0]                           addr_q;
	logic                                  out_valid_q;
	logic [22:0]                           offset_q;
	logic                                  ram_ok_q;

	cbm_pkg::bank_state_t                  st;
	logic                                  in_acc;
	logic                                  bus_we;
	logic                                  xlate;
	logic                                  div_done;
	logic [cbm_pkg::DIVIDEND_W-1:0]        div_rem;
	logic [cbm_pkg::DIVIDEND_W-1:0]        dividend;
	logic [cbm_pkg::DIVISOR_W-1:0]         divisor;
	logic [6:0]                            mbc1_bank;
	logic                                  out_free;
	logic [8:0]                            rom_bank;
	logic                                  ram_en;
	logic [22:0]                           next_offset;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ST_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign bus_we    = in_acc && (kind == cbm_pkg::KIND_WRITE);
	assign xlate     = in_acc && (kind == cbm_pkg::KIND_ROM || kind == cbm_pkg::KIND_RAM);
	assign out_free  = !out_valid_q || out_ready;

	cbm_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.bus_we    (bus_we),
		.bus_addr  (address),
		.bus_data  (data_byte),
		.st        (st)
	);

	always_comb begin
		mbc1_bank = st.bank_mode ? {2'b00, st.low_bank} : {st.high_bank, st.low_bank};
		if (mbc1_bank[4:0] == 5'd0) begin
			mbc1_bank[0] = 1'b1;
		end
		if (kind == cbm_pkg::KIND_ROM) begin
			divisor = (st.rom_banks == '0) ? cbm_pkg::DIVISOR_W'(2) : st.rom_banks;
			if (st.map != cbm_pkg::MAP_MBC1) begin
				dividend = st.wide_rom_bank;
			end else if (!address[14]) begin
				dividend = st.bank_mode ? {2'b00, st.high_bank, 5'd0} : '0;
			end else begin
				dividend = {2'b00, mbc1_bank};
			end
		end else begin
			divisor = (st.ram_banks == '0) ? '1 : {5'd0, st.ram_banks};
			if (st.map != cbm_pkg::MAP_MBC1) begin
				dividend = {1'b0, st.wide_ram_sel};
			end else begin
				dividend = st.bank_mode ? {7'd0, st.high_bank} : '0;
			end
		end
	end

	cbm_divrem u_divrem (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (xlate),
		.dividend (dividend),
		.divisor  (divisor),
		.done     (div_done),
		.rem      (div_rem)
	);

	always_comb begin
		rom_bank = div_rem;
		if (st.map != cbm_pkg::MAP_MBC1 && !addr_q[14]) begin
			rom_bank = '0;
		end else if (st.map == cbm_pkg::MAP_MBC1 && addr_q[14] && div_rem == '0) begin
			rom_bank = 9'd1;
		end
		ram_en = st.ram_enable && (addr_q[15:13] == cbm_pkg::RAM_WINDOW)
			&& !(st.map == cbm_pkg::MAP_MBC3 && st.wide_ram_sel > 8'd3);
		if (is_rom_q) begin
			next_offset = addr_q[15] ? '0 : {rom_bank, addr_q[13:0]};
		end else begin
			next_offset = ram_en ? {1'b0, div_rem, addr_q[12:0]} : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (xlate) begin
						state_q <= ST_BUSY;
					end
				end
				ST_BUSY: begin
					if (div_done && out_free) begin
						state_q     <= ST_IDLE;
						out_valid_q <= 1'b1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (xlate) begin
			is_rom_q <= (kind == cbm_pkg::KIND_ROM);
			addr_q   <= address;
		end
		if (state_q == ST_BUSY && div_done && out_free) begin
			offset_q <= next_offset;
			ram_ok_q <= !is_rom_q && ram_en;
		end
	end

	assign out_valid = out_valid_q;
	assign offset    = offset_q;
	assign ram_ok    = ram_ok_q;

endmodule

// ===== tb/sv/bank_map_checker.sv =====
`timescale 1ns / 1ps

module bank_map_checker
	import cbm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [9:0]  cfg_data,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [1:0]  kind,
	input  logic [15:0] address,
	input  logic [7:0]  data_byte,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [22:0] offset,
	input  logic        ram_ok,
	output int          errors,
	output int          pending
);

	typedef struct packed {
		logic [22:0] offset;
		logic        ram_ok;
	} xlat_t;

	xlat_t awaited_xlat[$];
	xlat_t want;
	int    mismatches;

	logic [7:0] cart_type;
	logic [9:0] rom_banks;
	logic [4:0] ram_banks;

	logic       ram_en;
	logic [4:0] low_bank;
	logic [1:0] high_bank;
	logic       mode1;
	logic [8:0] rom_sel;
	logic [7:0] ram_sel;

	assign errors = mismatches;

	function automatic map_t mapper_family(input logic [7:0] ct);
		if (ct >= MBC3_FIRST && ct <= MBC3_LAST) begin
			return MAP_MBC3;
		end
		if (ct >= MBC5_FIRST && ct <= MBC5_LAST) begin
			return MAP_MBC5;
		end
		return MAP_MBC1;
	endfunction

	function automatic int unsigned rom_reduce(input int unsigned bank);
		int unsigned n;
		n = (rom_banks == 0) ? 2 : rom_banks;
		return bank % n;
	endfunction

	function automatic int unsigned ram_reduce(input int unsigned bank);
		return (ram_banks == 0) ? bank : bank % ram_banks;
	endfunction

	function automatic xlat_t translate(input logic [1:0] k, input logic [15:0] a);
		xlat_t       r;
		int unsigned bank;
		int unsigned off;
		logic        en;
		map_t        fam;
		fam = mapper_family(cart_type);
		r = '0;
		off = 0;
		bank = 0;
		if (k == KIND_ROM) begin
			if (a < 16'h8000) begin
				if (fam != MAP_MBC1) begin
					if (a < 16'h4000) begin
						off = a;
					end else begin
						off = rom_reduce(rom_sel) * 32'h4000 + (a - 16'h4000);
					end
				end else if (a < 16'h4000) begin
					bank = mode1 ? {high_bank, 5'b0} : 0;
					off = rom_reduce(bank) * 32'h4000 + a;
				end else begin
					bank = low_bank;
					if (!mode1) begin
						bank = bank | {high_bank, 5'b0};
					end
					if (bank[4:0] == 0) begin
						bank++;
					end
					bank = rom_reduce(bank);
					// MBC1 can never map bank 0 into the switched window
					if (bank == 0) begin
						bank = 1;
					end
					off = bank * 32'h4000 + (a - 16'h4000);
				end
			end
		end else begin
			en = ram_en && a >= 16'hA000 && a < 16'hC000;
			case (fam)
				MAP_MBC3: begin
					// selects above 3 address the clock registers
					if (ram_sel > 8'h03) begin
						en = 1'b0;
					end else begin
						bank = ram_reduce(ram_sel);
					end
				end
				MAP_MBC5: begin
					bank = ram_reduce(ram_sel);
				end
				default: begin
					if (mode1) begin
						bank = ram_reduce(high_bank);
					end
				end
			endcase
			r.ram_ok = en;
			if (en) begin
				off = bank * 32'h2000 + (a - 16'hA000);
			end
		end
		r.offset = off[22:0];
		return r;
	endfunction

	task automatic bus_write(input logic [15:0] a, input logic [7:0] d);
		map_t fam;
		fam = mapper_family(cart_type);
		if (a < 16'h2000) begin
			ram_en = (d[3:0] == RAM_EN_KEY);
		end else if (fam == MAP_MBC3) begin
			if (a < 16'h4000) begin
				rom_sel = (d[6:0] == 0) ? 9'd1 : {2'b0, d[6:0]};
			end else if (a < 16'h6000) begin
				ram_sel = d;
			end
		end else if (fam == MAP_MBC5) begin
			if (a < 16'h3000) begin
				rom_sel[7:0] = d;
			end else if (a < 16'h4000) begin
				rom_sel[8] = d[0];
			end else if (a < 16'h6000) begin
				ram_sel = {4'b0, d[3:0]};
			end
		end else begin
			if (a < 16'h4000) begin
				low_bank = (d[4:0] == 0) ? 5'd1 : d[4:0];
			end else if (a < 16'h6000) begin
				high_bank = d[1:0];
			end else if (a < 16'h8000) begin
				mode1 = d[0];
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cart_type = 8'h00;
			rom_banks = 10'd2;
			ram_banks = 5'd0;
			ram_en = 1'b0;
			low_bank = 5'd1;
			high_bank = 2'd0;
			mode1 = 1'b0;
			rom_sel = 9'd1;
			ram_sel = 8'd0;
			awaited_xlat.delete();
			mismatches = 0;
			pending <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (awaited_xlat.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("%0t: unexpected result offset=%h ram_ok=%b",
							$time, offset, ram_ok);
					end
				end else begin
					want = awaited_xlat.pop_front();
					if (want.offset !== offset || want.ram_ok !== ram_ok) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("%0t: offset exp %h got %h, ram_ok exp %b got %b",
								$time, want.offset, offset, want.ram_ok, ram_ok);
						end
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_CART_TYPE: cart_type = cfg_data[7:0];
					CFG_ROM_BANKS: rom_banks = cfg_data;
					CFG_RAM_BANKS: ram_banks = cfg_data[4:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				if (kind == KIND_WRITE) begin
					bus_write(address, data_byte);
				end else if (kind == KIND_ROM || kind == KIND_RAM) begin
					awaited_xlat.push_back(translate(kind, address));
				end
			end
			pending <= awaited_xlat.size();
		end
	end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
	import cbm_pkg::*;

	localparam logic [1:0] KIND_UNUSED = 2'd3;
	localparam int HOLD_CYCLES = 300;
	localparam int SETTLE = 16;
	localparam int PHASES = 10;
	localparam int PHASE_ITEMS = 55;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic [1:0]  cfg_index = CFG_CART_TYPE;
	logic [9:0]  cfg_data = '0;
	logic        in_valid = 1'b0;
	logic [1:0]  kind = KIND_WRITE;
	logic [15:0] address = '0;
	logic [7:0]  data_byte = '0;
	logic        out_ready = 1'b0;

	logic        cfg_ready;
	logic        in_ready;
	logic        out_valid;
	logic [22:0] offset;
	logic        ram_ok;

	int errors;
	int pending;
	int send_idle = 10;
	int recv_idle = 54;
	int hold_requests = 0;
	int holds_done = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	cartridge_bank_mapper dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.kind      (kind),
		.address   (address),
		.data_byte (data_byte),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.offset    (offset),
		.ram_ok    (ram_ok)
	);

	bank_map_checker map_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.kind      (kind),
		.address   (address),
		.data_byte (data_byte),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.offset    (offset),
		.ram_ok    (ram_ok),
		.errors    (errors),
		.pending   (pending)
	);

	initial begin
		#5_000_000;
		$display("testbench: FAIL");
		$finish;
	end

	// result side: random stalls, plus long hold-offs on request
	initial begin
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_requests != holds_done) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				holds_done++;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_idle);
			end
		end
	end

	task automatic send_item(input logic [1:0] k, input logic [15:0] a, input logic [7:0] d);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		address <= a;
		data_byte <= d;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [9:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
	endtask

	task automatic set_config(input logic [7:0] ct, input logic [9:0] rb, input logic [4:0] rab);
		drain();
		repeat (SETTLE) @(posedge clk);
		write_reg(CFG_CART_TYPE, {2'b0, ct});
		write_reg(CFG_ROM_BANKS, rb);
		write_reg(CFG_RAM_BANKS, {5'b0, rab});
		cfg_valid <= 1'b0;
	endtask

	// mostly bank-register writes and in-window translations, some noise
	task automatic send_random_item();
		logic [1:0]  k;
		logic [15:0] a;
		logic [7:0]  d;
		int          pick;
		pick = $urandom_range(99);
		d = 8'($urandom_range(255));
		if (pick < 38) begin
			k = KIND_WRITE;
			if ($urandom_range(9) < 8) begin
				a = 16'($urandom_range(16'h7FFF));
				if (a < 16'h2000 && $urandom_range(1) == 1) begin
					d[3:0] = RAM_EN_KEY;
				end else if (a >= 16'h4000 && a < 16'h6000 && $urandom_range(1) == 1) begin
					d = 8'($urandom_range(3));
				end
			end else begin
				a = 16'($urandom_range(16'hFFFF));
			end
		end else if (pick < 68) begin
			k = KIND_ROM;
			a = ($urandom_range(9) < 9) ? 16'($urandom_range(16'h7FFF))
				: 16'($urandom_range(16'hFFFF));
		end else if (pick < 96) begin
			k = KIND_RAM;
			a = ($urandom_range(9) < 8) ? 16'($urandom_range(16'hBFFF, 16'hA000))
				: 16'($urandom_range(16'hFFFF));
		end else begin
			k = KIND_UNUSED;
			a = 16'($urandom_range(16'hFFFF));
		end
		send_item(k, a, d);
	endtask

	initial begin
		logic [7:0] ct;
		logic [9:0] rb;
		logic [4:0] rab;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset configuration: MBC1, 2 ROM banks, no RAM modulo
		send_item(KIND_ROM, 16'h0000, 8'h00);
		send_item(KIND_ROM, 16'h7FFF, 8'hFF);
		send_item(KIND_ROM, 16'hFFFF, 8'h00);
		send_item(KIND_RAM, 16'hA000, 8'h00);
		send_item(KIND_WRITE, 16'h0000, 8'h0A);
		send_item(KIND_RAM, 16'hBFFF, 8'h00);
		send_item(KIND_RAM, 16'h9FFF, 8'h00);
		send_item(KIND_RAM, 16'hC000, 8'h00);
		send_item(KIND_WRITE, 16'h2000, 8'h00);
		send_item(KIND_WRITE, 16'h3FFF, 8'hE2);
		send_item(KIND_ROM, 16'h4000, 8'h00);
		send_item(KIND_WRITE, 16'h5FFF, 8'hFF);
		send_item(KIND_WRITE, 16'h7FFF, 8'h01);
		send_item(KIND_ROM, 16'h3FFF, 8'h00);
		send_item(KIND_RAM, 16'hA5A5, 8'h00);
		send_item(KIND_UNUSED, 16'hFFFF, 8'hFF);
		send_item(KIND_WRITE, 16'h8000, 8'h0A);

		// MBC3 with a zero ROM bank count, registers carried over
		set_config(8'h0F, 10'd0, 5'd0);
		send_item(KIND_WRITE, 16'h2000, 8'h80);
		send_item(KIND_ROM, 16'h7FFF, 8'h00);
		send_item(KIND_WRITE, 16'h4000, 8'h08);
		send_item(KIND_RAM, 16'hA000, 8'h00);
		send_item(KIND_WRITE, 16'h6000, 8'h01);
		send_item(KIND_WRITE, 16'h4000, 8'h03);
		send_item(KIND_RAM, 16'hBFFF, 8'h00);

		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: begin ct = 8'h01; rb = 10'd128; rab = 5'd4; end
				1: begin ct = 8'h0F; rb = 10'd512; rab = 5'd4; end
				2: begin ct = 8'h1E; rb = 10'd512; rab = 5'd16; end
				3: begin ct = 8'hFF; rb = 10'd1; rab = 5'd0; end
				4: begin ct = 8'h13; rb = 10'd0; rab = 5'd1; end
				5: begin ct = 8'h19; rb = 10'd3; rab = 5'd3; end
				6: begin ct = 8'h0E; rb = 10'd64; rab = 5'd2; end
				default: begin
					case ($urandom_range(5))
						0: ct = 8'h14;
						1: ct = 8'h18;
						2: ct = 8'h1F;
						3: ct = 8'h10;
						4: ct = 8'h1A;
						default: ct = 8'($urandom_range(255));
					endcase
					rb = 10'($urandom_range(512, 1));
					rab = 5'($urandom_range(16));
				end
			endcase
			if (p < 4) begin
				send_idle = 10;
				recv_idle = 54;
			end else if (p < 7) begin
				send_idle = 54;
				recv_idle = 10;
			end else begin
				send_idle = 0;
				recv_idle = 0;
			end
			set_config(ct, rb, rab);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (p == 0 && i == 10) begin
					hold_requests++;
				end
				if (p == 5 && i == 20) begin
					drain();
				end
				send_random_item();
			end
		end

		drain();
		repeat (SETTLE) @(posedge clk);
		if (errors == 0) begin
			$display("testbench: PASS");
		end else begin
			$display("testbench: FAIL");
		end
		$finish;
	end

endmodule
